// File: rtl/core/infix_to_postfix_converter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the infix-to-postfix converter
// Shared concurrent checks, clocked on clock and held off during reset.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// Same-cycle implication.
`define I2P_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define I2P_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/i2p_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_pkg
// Character codes, error codes, sequencer states and shared structs.
// ----------------------------------------------------------------------------
package i2p_pkg;

   localparam int unsigned STACK_DEPTH_DEFAULT = 32;
   localparam int unsigned CHAR_W              = 8;
   localparam int unsigned ERR_W               = 2;

   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
   localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_TERM  = 8'h00;

   localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_UNMATCHED = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_READ,
      ST_CHECK,
      ST_PUSH,
      ST_FLUSH_READ,
      ST_FLUSH_CHECK,
      ST_TERM
   } seq_state_type;

   // One postfix character headed for the output register
   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] data;
      logic              last;
      logic [ERR_W-1:0]  err;
   } emit_type;

   // Stack memory strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctl_type;

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_add(input logic [CHAR_W-1:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS);
   endfunction

   function automatic logic is_mul(input logic [CHAR_W-1:0] c);
      return (c == CH_STAR) || (c == CH_SLASH);
   endfunction

   // True when incoming operator c must pop stack top t first
   function automatic logic yields_to(input logic [CHAR_W-1:0] c,
                                      input logic [CHAR_W-1:0] t);
      logic res;
      res = 1'b0;
      if (is_add(c)) begin
         res = is_mul(t) || is_add(t);
      end else if (is_mul(c)) begin
         res = is_mul(t);
      end
      return res;
   endfunction

endpackage

// File: rtl/core/i2p_stack_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_stack_ram
// Operator stack storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module i2p_stack_ram #(
   parameter int unsigned STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  i2p_pkg::ram_ctl_type             ctl,
   input  logic [$clog2(STACK_DEPTH)-1:0]   wr_addr,
   input  logic [i2p_pkg::CHAR_W-1:0]       wr_data,
   input  logic [$clog2(STACK_DEPTH)-1:0]   rd_addr,
   output logic [i2p_pkg::CHAR_W-1:0]       rd_data
);
   import i2p_pkg::*;

   logic [CHAR_W-1:0] stack_mem [STACK_DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/i2p_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_out_stage
// Output register for the result stream; frees when the consumer takes it.
// ----------------------------------------------------------------------------
module i2p_out_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  i2p_pkg::emit_type             emit,
   output logic                          out_free,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [i2p_pkg::CHAR_W-1:0]    rsp_tdata,
   output logic                          rsp_tlast,
   output logic [i2p_pkg::ERR_W-1:0]     rsp_tuser
);
   import i2p_pkg::*;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [CHAR_W-1:0] rsp_data_ff;
   logic              rsp_last_ff;
   logic [ERR_W-1:0]  rsp_err_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload loads on every emit; the sequencer emits only when the slot is free
   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_data_ff <= emit.data;
         rsp_last_ff <= emit.last;
         rsp_err_ff  <= emit.err;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

// File: rtl/core/i2p_seq.sv
`timescale 1ns / 1ps
`include "infix_to_postfix_converter_assert.svh"
// ----------------------------------------------------------------------------
// i2p_seq
// Shunting-yard sequencer: classifies a character, emits digits, walks the stack
// memory top first, pushes, flushes, flags errors and emits the terminator.
// ----------------------------------------------------------------------------
module i2p_seq #(
   parameter int unsigned STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [i2p_pkg::CHAR_W-1:0]       req_char,
   input  logic                             req_last,
   output i2p_pkg::ram_ctl_type             ram_ctl,
   output logic [$clog2(STACK_DEPTH)-1:0]   wr_addr,
   output logic [$clog2(STACK_DEPTH)-1:0]   rd_addr,
   output logic [i2p_pkg::CHAR_W-1:0]       wr_data,
   input  logic [i2p_pkg::CHAR_W-1:0]       rd_data,
   output i2p_pkg::emit_type                emit,
   input  logic                             out_free
);
   import i2p_pkg::*;

   localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
   localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);

   seq_state_type     state_ff, state_in, done_state;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic              last_ff, last_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ERR_W-1:0]  err_ff, err_in;
   logic              count_zero, count_one, count_full;

   assign count_zero = (count_ff == '0);
   assign count_one  = (count_ff == CNT_W'(1));
   assign count_full = (count_ff == CNT_W'(STACK_DEPTH));
   assign done_state = last_ff ? ST_FLUSH_READ : ST_IDLE;

   assign wr_addr = count_ff[ADDR_W-1:0];
   assign rd_addr = ADDR_W'(count_ff - CNT_W'(1));
   assign wr_data = ch_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (is_digit(ch_ff)) begin
               if (out_free) begin
                  state_in = done_state;
               end
            end else if (ch_ff == CH_OPEN) begin
               state_in = ST_PUSH;
            end else if (ch_ff == CH_CLOSE) begin
               state_in = count_zero ? done_state : ST_READ;
            end else begin
               state_in = count_zero ? ST_PUSH : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (ch_ff == CH_CLOSE) begin
               if (rd_data == CH_OPEN) begin
                  state_in = done_state;
               end else if (out_free) begin
                  state_in = count_one ? done_state : ST_READ;
               end
            end else if (!yields_to(ch_ff, rd_data)) begin
               state_in = ST_PUSH;
            end else if (out_free) begin
               state_in = count_one ? ST_PUSH : ST_READ;
            end
         end
         ST_PUSH: begin
            state_in = done_state;
         end
         ST_FLUSH_READ: begin
            state_in = count_zero ? ST_TERM : ST_FLUSH_CHECK;
         end
         ST_FLUSH_CHECK: begin
            if (out_free) begin
               state_in = ST_FLUSH_READ;
            end
         end
         ST_TERM: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath updates
   always_comb begin
      req_ready = 1'b0;
      ram_ctl   = '0;
      emit      = '0;
      ch_in     = ch_ff;
      last_in   = last_ff;
      count_in  = count_ff;
      err_in    = err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ch_in   = req_char;
               last_in = req_last;
            end
         end
         ST_DISPATCH: begin
            if (is_digit(ch_ff)) begin
               if (out_free) begin
                  emit.valid = 1'b1;
                  emit.data  = ch_ff;
               end
            end else if ((ch_ff == CH_CLOSE) && count_zero) begin
               if (err_ff == ERR_NONE) begin
                  err_in = ERR_UNMATCHED;
               end
            end
         end
         ST_READ: begin
            ram_ctl.rd_en = 1'b1;
         end
         ST_CHECK: begin
            if (ch_ff == CH_CLOSE) begin
               if (rd_data == CH_OPEN) begin
                  count_in = count_ff - CNT_W'(1);
               end else if (out_free) begin
                  emit.valid = 1'b1;
                  emit.data  = rd_data;
                  count_in   = count_ff - CNT_W'(1);
                  if (count_one && (err_ff == ERR_NONE)) begin
                     err_in = ERR_UNMATCHED;
                  end
               end
            end else if (yields_to(ch_ff, rd_data) && out_free) begin
               emit.valid = 1'b1;
               emit.data  = rd_data;
               count_in   = count_ff - CNT_W'(1);
            end
         end
         ST_PUSH: begin
            if (count_full) begin
               if (err_ff == ERR_NONE) begin
                  err_in = ERR_OVERFLOW;
               end
            end else begin
               ram_ctl.wr_en = 1'b1;
               count_in      = count_ff + CNT_W'(1);
            end
         end
         ST_FLUSH_READ: begin
            ram_ctl.rd_en = !count_zero;
         end
         ST_FLUSH_CHECK: begin
            if (out_free) begin
               emit.valid = 1'b1;
               emit.data  = rd_data;
               count_in   = count_ff - CNT_W'(1);
            end
         end
         ST_TERM: begin
            if (out_free) begin
               emit.valid = 1'b1;
               emit.data  = CH_TERM;
               emit.last  = 1'b1;
               emit.err   = err_ff;
               err_in     = ERR_NONE;
               count_in   = '0;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         err_ff   <= ERR_NONE;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff   <= ch_in;
      last_ff <= last_in;
   end

   `I2P_ASSERT_IMP(a_emit_needs_slot, emit.valid, out_free, "emit while output slot busy")
   `I2P_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_W'(STACK_DEPTH), "stack count overrun")
   `I2P_ASSERT_NXT(a_term_clears, emit.valid && emit.last, (count_ff == '0) && (err_ff == ERR_NONE), "terminator left state")
   `I2P_ASSERT_NXT(a_read_then_check, state_ff == ST_READ, state_ff == ST_CHECK, "read not followed by check")

endmodule

// File: rtl/core/infix_to_postfix_converter.sv
// Timing: a digit passes from the dispatch state into the output register, which
//   raises rsp_tvalid; each stack entry read is a memory read state, then a compare/emit
//   state, and a push is a push state. One item is taken at a time; a final item then reads
//   and emits each flushed entry in turn, checks the empty stack and emits the terminator.
//   The registered memory read needs its own read state; output stalls add more.
// Reset: synchronous, active high; idles the sequencer, empties the stack and output, clears the sticky error.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard infix-to-postfix conversion over a bounded operator stack
// held in a synchronous memory, with a registered result stream.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
   parameter int unsigned STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input character stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // [7:0] in_char
   input  logic                          req_tlast,  // in_last
   // Postfix result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,  // [7:0] out_char
   output logic                          rsp_tlast,  // out_last
   output logic [1:0]                    rsp_tuser   // [1:0] out_error
);
   import i2p_pkg::*;

   localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);

   ram_ctl_type         ram_ctl;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic [CHAR_W-1:0]   wr_data;
   logic [CHAR_W-1:0]   rd_data;
   emit_type            emit;
   logic                out_free;

   // Sequencer: takes one transaction at a time, walks the stack top first
   i2p_seq #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_char  (req_tdata),
      .req_last  (req_tlast),
      .ram_ctl   (ram_ctl),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .wr_data   (wr_data),
      .rd_data   (rd_data),
      .emit      (emit),
      .out_free  (out_free)
   );

   // Operator stack: write and read never target the same entry in one cycle,
   // since a push ends an item and the next read is issued later
   i2p_stack_ram #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output register: hold a result until the consumer takes it
   i2p_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
